[design/b64d_pkg.sv]
// b64d_pkg: types and constants for the base64 stream decoder
// no dependencies; imported by b64d_char_map and base64_stream_decoder_core
`timescale 1ns / 1ps

package b64d_pkg;

    typedef struct packed {
        logic [7:0] enc_char;
        logic       is_final;
    } char_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       bad_char;
        logic       bad_length;
    } byte_item_t;

    typedef struct packed {
        logic [5:0] sextet;
        logic       bad;
    } char_map_t;

    localparam logic [5:0] SEXTET_LOWER_BASE = 6'h1A;
    localparam logic [5:0] SEXTET_DIGIT_BASE = 6'h34;
    localparam logic [5:0] SEXTET_PLUS       = 6'h3E;
    localparam logic [5:0] SEXTET_SLASH      = 6'h3F;
    localparam logic [5:0] SEXTET_INVALID    = 6'h3F;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;

endpackage

[design/b64d_char_map.sv]
// b64d_char_map: maps one base64 character to its sextet and an invalid flag
// depends on b64d_pkg
`timescale 1ns / 1ps

module b64d_char_map
    import b64d_pkg::*;
(
    input  logic [7:0] enc_char,
    output char_map_t  map
);

    logic [7:0] upper_off;
    logic [7:0] lower_off;
    logic [7:0] digit_off;

    assign upper_off = enc_char - CHAR_UPPER_A;
    assign lower_off = enc_char - CHAR_LOWER_A;
    assign digit_off = enc_char - CHAR_DIGIT_0;

    always_comb
    begin
        map.bad    = 1'b0;
        map.sextet = SEXTET_INVALID;
        if (enc_char >= CHAR_UPPER_A && enc_char <= CHAR_UPPER_Z)
        begin
            map.sextet = upper_off[5:0];
        end
        else if (enc_char >= CHAR_LOWER_A && enc_char <= CHAR_LOWER_Z)
        begin
            map.sextet = SEXTET_LOWER_BASE + lower_off[5:0];
        end
        else if (enc_char >= CHAR_DIGIT_0 && enc_char <= CHAR_DIGIT_9)
        begin
            map.sextet = SEXTET_DIGIT_BASE + digit_off[5:0];
        end
        else if (enc_char == CHAR_PLUS)
        begin
            map.sextet = SEXTET_PLUS;
        end
        else if (enc_char == CHAR_SLASH)
        begin
            map.sextet = SEXTET_SLASH;
        end
        else
        begin
            map.bad = 1'b1;
        end
    end

endmodule

[design/base64_stream_decoder_core.sv]
// base64_stream_decoder_core: unpadded base64 decoder, one character per request
// depends on b64d_pkg and b64d_char_map
`timescale 1ns / 1ps

// Usage:
//   char channel (char_valid, char_stall, char_data) takes one encoded character
//   per request; char_data.is_final marks the last character of a stream.
//   byte channel (byte_valid, byte_stall, byte_data) returns decoded bytes.
//   The first character of each group of four gives no result; the second,
//   third and fourth each give one byte. A stream ending one character past
//   a group boundary gives a single result with bad_length set and a zero byte.
//   bad_char flags any character outside the alphabet since the last result.
//   out_last marks the final result of a stream; the next character starts anew.
//   A character is held in the input register; its result is then registered
//   in the result register.
//   Throughput: one character per cycle while char_stall is low, set by the single decode stage.
//   Reset clears group position, held sextet and both valid registers.
//   When byte_stall is high the result holds; the input register keeps one
//   more character and char_stall rises only while both registers are full.

module base64_stream_decoder_core
    import b64d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_stall,
    input  char_item_t char_data,
    output logic       byte_valid,
    input  logic       byte_stall,
    output byte_item_t byte_data
);

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_THIRD,
        PH_FOURTH
    } phase_t;

    logic       in_vld_reg;
    logic       in_vld_next;
    char_item_t in_data_reg;

    logic       res_vld_reg;
    logic       res_vld_next;
    byte_item_t res_data_reg;
    byte_item_t res_data_next;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [5:0] held_reg;
    logic [5:0] held_next;
    logic       pend_reg;
    logic       pend_next;

    logic       advance;
    logic       take;
    logic       bad_any;
    logic [7:0] dec_byte;
    char_map_t  cmap;

    b64d_char_map u_char_map (
        .enc_char (in_data_reg.enc_char),
        .map      (cmap)
    );

    assign advance    = !res_vld_reg || !byte_stall;
    assign char_stall = in_vld_reg && !advance;
    assign take       = char_valid && !char_stall;
    assign bad_any    = pend_reg | cmap.bad;

    assign byte_valid = res_vld_reg;
    assign byte_data  = res_data_reg;

    always_comb
    begin
        unique case (phase_reg)
            PH_SECOND: dec_byte = {held_reg, cmap.sextet[5:4]};
            PH_THIRD:  dec_byte = {held_reg[3:0], cmap.sextet[5:2]};
            PH_FOURTH: dec_byte = {held_reg[1:0], cmap.sextet};
            default:   dec_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        in_vld_next   = in_vld_reg;
        res_vld_next  = res_vld_reg;
        res_data_next = res_data_reg;
        phase_next    = phase_reg;
        held_next     = held_reg;
        pend_next     = pend_reg;

        if (advance)
        begin
            in_vld_next  = take;
            res_vld_next = 1'b0;
            if (in_vld_reg)
            begin
                res_data_next.out_last = in_data_reg.is_final;
                res_data_next.bad_char = bad_any;
                if (phase_reg == PH_FIRST)
                begin
                    res_data_next.out_byte   = 8'h00;
                    res_data_next.bad_length = 1'b1;
                    res_vld_next             = in_data_reg.is_final;
                    phase_next               = PH_SECOND;
                    held_next                = cmap.sextet;
                    pend_next                = bad_any;
                end
                else
                begin
                    res_data_next.out_byte   = dec_byte;
                    res_data_next.bad_length = 1'b0;
                    res_vld_next             = 1'b1;
                    held_next                = cmap.sextet;
                    pend_next                = 1'b0;
                    unique case (phase_reg)
                        PH_SECOND: phase_next = PH_THIRD;
                        PH_THIRD:  phase_next = PH_FOURTH;
                        default:   phase_next = PH_FIRST;
                    endcase
                end
                if (in_data_reg.is_final)
                begin
                    phase_next = PH_FIRST;
                    held_next  = 6'h00;
                    pend_next  = 1'b0;
                end
            end
        end
        else if (take)
        begin
            in_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
            phase_reg   <= PH_FIRST;
            held_reg    <= 6'h00;
            pend_reg    <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            res_vld_reg <= res_vld_next;
            phase_reg   <= phase_next;
            held_reg    <= held_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_data_reg <= char_data;
        end
        res_data_reg <= res_data_next;
    end

endmodule
